// ===== rtl/tpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfa_pkg
// Shared codes and types of the thermal packet frame assembler.
// ----------------------------------------------------------------------------
package tpfa_pkg;

	typedef logic [15:0] pixel_t;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	localparam logic CFG_PACKET_LIMIT      = 1'b0;
	localparam logic CFG_SUCCESS_THRESHOLD = 1'b1;

	localparam logic [9:0] LIMIT_RESET  = 10'd800;
	localparam logic [7:0] THRESH_RESET = 8'd180;

	localparam logic [15:0] DISCARD_MASK = 16'h0F00;

endpackage

// ===== rtl/tpfa_store.sv =====
// ----------------------------------------------------------------------------
// tpfa_store
// Single-port pixel memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tpfa_store #(
	parameter int DEPTH  = 19200,
	parameter int ADDR_W = 15
) (
	input  logic                clk,
	input  logic                en,
	input  logic                we,
	input  logic [ADDR_W-1:0]   addr,
	input  tpfa_pkg::pixel_t    wdata,
	output tpfa_pkg::pixel_t    rdata
);

	tpfa_pkg::pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/thermal_packet_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// thermal_packet_frame_assembler
// Reassembles link bytes into packets and writes their pixels to an image
// store; reports on capture end and serves pixel readback.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries start, byte and readback requests.
// Output channel (out_valid/out_ready) carries capture reports and pixels.
// Configuration writes (cfg_we) are taken at any time.
// After reset and after every start the store is cleared, one word a cycle,
// and in_ready is low throughout. A start with a zero packet limit reports
// once that pass is done. A pixel low byte of an accepted packet reads its
// word, then writes it on the single memory port only if the word is still
// zero; the second header byte judges the header and forms the row index,
// then the base address; the last byte of a packet updates the counters and,
// when capture ends, loads the report. A readback waits on the registered
// memory read data.
// Results sit in an output register; the next request is accepted while one
// waits. An item that has a result holds in its final state while the
// receiver stalls and the output register is still full.
// ----------------------------------------------------------------------------
module thermal_packet_frame_assembler #(
	parameter int ROW_PIXELS      = 160,
	parameter int ROW_COUNT       = 120,
	parameter int PACKET_PIXELS   = 80,
	parameter int SEGMENT_PACKETS = 60,
	parameter int FRAME_SEGMENTS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	input  logic [14:0] pixel_index,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [15:0] pixel_value,
	output logic        capture_ok,
	output logic [7:0]  accepted_count,
	output logic [9:0]  read_count,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int STORE_DEPTH   = ROW_PIXELS * ROW_COUNT;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int PACKET_BYTES  = 4 + 2 * PACKET_PIXELS;
	localparam int POS_W         = $clog2(PACKET_BYTES);
	localparam int FRAME_PACKETS = SEGMENT_PACKETS * FRAME_SEGMENTS;
	localparam int R_W           = $clog2(FRAME_PACKETS + 1);
	localparam int VALID_W       = $clog2(FRAME_PACKETS + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_JUDGE,
		S_BASE,
		S_PXCHK,
		S_END,
		S_REPORT,
		S_RDOUT
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]  clr_addr_q;
	logic               rep_pend_q;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         hold_q;
	logic [15:0]        hdr_q;
	logic               hdr_ok_q;
	logic [R_W-1:0]     r_q;
	logic               acc_q;
	logic [ADDR_W-1:0]  base_q;
	logic [9:0]         seen_q;
	logic [VALID_W-1:0] valid_q;
	logic               active_q;
	logic [9:0]         limit_q;
	logic [7:0]         thresh_q;
	logic [7:0]         lo_q;
	logic [ADDR_W-1:0]  pix_addr_q;
	logic               last_q;
	logic               rd_zero_q;

	logic               out_valid_q;
	logic               kind_q;
	tpfa_pkg::pixel_t   pix_val_q;
	logic               ok_q;
	logic [7:0]         vcnt_q;
	logic [9:0]         rcnt_q;

	logic               mem_en;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_addr;
	tpfa_pkg::pixel_t   mem_wdata;
	tpfa_pkg::pixel_t   mem_rdata;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic [2:0]         seg;
	logic [11:0]        num;
	logic               hdr_ok;
	logic [31:0]        r_full;
	logic [31:0]        base_full;
	logic               base_fit;
	logic [POS_W-1:0]   pos_rel;
	logic [ADDR_W-1:0]  pix_addr;
	logic               is_last;
	logic               px_go;
	logic               rd_in_range;
	logic [9:0]         seen_next;
	logic [VALID_W-1:0] valid_next;
	logic               end_hit;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign out_load    = ((state_q == S_REPORT) || (state_q == S_RDOUT)) && out_free;

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign pixel_value    = pix_val_q;
	assign capture_ok     = ok_q;
	assign accepted_count = vcnt_q;
	assign read_count     = rcnt_q;

	assign seg    = hdr_q[14:12];
	assign num    = hdr_q[11:0];
	assign hdr_ok = ((hdr_q & tpfa_pkg::DISCARD_MASK) != tpfa_pkg::DISCARD_MASK)
		&& (seg != 3'd0) && (32'(seg) <= FRAME_SEGMENTS)
		&& (32'(num) < SEGMENT_PACKETS);
	assign r_full    = (32'(seg) - 32'd1) * SEGMENT_PACKETS + 32'(num);
	assign base_full = 32'(r_q >> 1) * ROW_PIXELS + (r_q[0] ? PACKET_PIXELS : 0);
	assign base_fit  = (base_full + PACKET_PIXELS) <= STORE_DEPTH;

	assign pos_rel  = pos_q - POS_W'(4);
	assign pix_addr = base_q + ADDR_W'(pos_rel >> 1);
	assign is_last  = (pos_q == POS_W'(PACKET_BYTES - 1));
	assign px_go    = accept && (req_type == tpfa_pkg::REQ_BYTE) && active_q
		&& (pos_q >= POS_W'(4)) && pos_q[0] && acc_q;
	assign rd_in_range = 32'(pixel_index) < STORE_DEPTH;

	assign seen_next  = seen_q + 10'd1;
	assign valid_next = valid_q + VALID_W'(acc_q);
	assign end_hit    = (seen_next >= limit_q) || (32'(valid_next) >= FRAME_PACKETS);

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = clr_addr_q;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_en = 1'b1;
			mem_we = 1'b1;
		end else if (state_q == S_PXCHK) begin
			mem_addr  = pix_addr_q;
			mem_wdata = {hold_q, lo_q};
			if (mem_rdata == '0) begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
		end else if (px_go) begin
			mem_en   = 1'b1;
			mem_addr = pix_addr;
		end else if (accept && (req_type == tpfa_pkg::REQ_READ) && rd_in_range) begin
			mem_en   = 1'b1;
			mem_addr = ADDR_W'(pixel_index);
		end
	end

	tpfa_store #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			rep_pend_q  <= 1'b0;
			pos_q       <= '0;
			hold_q      <= '0;
			hdr_q       <= '0;
			hdr_ok_q    <= 1'b0;
			r_q         <= '0;
			acc_q       <= 1'b0;
			base_q      <= '0;
			seen_q      <= '0;
			valid_q     <= '0;
			active_q    <= 1'b0;
			limit_q     <= tpfa_pkg::LIMIT_RESET;
			thresh_q    <= tpfa_pkg::THRESH_RESET;
			lo_q        <= '0;
			pix_addr_q  <= '0;
			last_q      <= 1'b0;
			rd_zero_q   <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= tpfa_pkg::KIND_REPORT;
			pix_val_q   <= '0;
			ok_q        <= 1'b0;
			vcnt_q      <= '0;
			rcnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tpfa_pkg::CFG_PACKET_LIMIT:      limit_q  <= cfg_data;
					tpfa_pkg::CFG_SUCCESS_THRESHOLD: thresh_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						rep_pend_q <= 1'b0;
						state_q    <= rep_pend_q ? S_REPORT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							tpfa_pkg::REQ_START: begin
								pos_q      <= '0;
								hold_q     <= '0;
								hdr_q      <= '0;
								acc_q      <= 1'b0;
								base_q     <= '0;
								seen_q     <= '0;
								valid_q    <= '0;
								clr_addr_q <= '0;
								rep_pend_q <= (limit_q == 10'd0);
								active_q   <= (limit_q != 10'd0);
								state_q    <= S_CLEAR;
							end
							tpfa_pkg::REQ_READ: begin
								rd_zero_q <= !rd_in_range;
								state_q   <= S_RDOUT;
							end
							tpfa_pkg::REQ_BYTE: begin
								if (active_q) begin
									pos_q <= is_last ? '0 : pos_q + POS_W'(1);
									if (pos_q == POS_W'(0)) begin
										hold_q <= rx_byte;
									end else if (pos_q == POS_W'(1)) begin
										hdr_q   <= {hold_q, rx_byte};
										state_q <= S_JUDGE;
									end else if (pos_q >= POS_W'(4) && !pos_q[0]) begin
										hold_q <= rx_byte;
									end
									if (px_go) begin
										lo_q       <= rx_byte;
										pix_addr_q <= pix_addr;
										last_q     <= is_last;
										state_q    <= S_PXCHK;
									end else if (is_last) begin
										state_q <= S_END;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_JUDGE: begin
					r_q      <= R_W'(r_full);
					hdr_ok_q <= hdr_ok;
					state_q  <= S_BASE;
				end
				S_BASE: begin
					acc_q   <= hdr_ok_q && base_fit;
					base_q  <= ADDR_W'(base_full);
					state_q <= S_IDLE;
				end
				S_PXCHK: begin
					state_q <= last_q ? S_END : S_IDLE;
				end
				S_END: begin
					seen_q  <= seen_next;
					valid_q <= valid_next;
					acc_q   <= 1'b0;
					if (end_hit) begin
						active_q <= 1'b0;
						state_q  <= S_REPORT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						kind_q    <= tpfa_pkg::KIND_REPORT;
						pix_val_q <= '0;
						ok_q      <= (32'(valid_q) >= 32'(thresh_q));
						vcnt_q    <= 8'(32'(valid_q));
						rcnt_q    <= seen_q;
						state_q   <= S_IDLE;
					end
				end
				S_RDOUT: begin
					if (out_free) begin
						kind_q    <= tpfa_pkg::KIND_PIXEL;
						pix_val_q <= rd_zero_q ? '0 : mem_rdata;
						ok_q      <= 1'b0;
						vcnt_q    <= '0;
						rcnt_q    <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/tb_thermal_packet_frame_assembler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermal_packet_frame_assembler
// Self-checking bench for the packet frame assembler. A scoreboard class
// tracks packet framing, header judgment, write-once pixel storage and
// capture counters. It predicts every report and readback and checks each
// result transfer in order. Stimulus starts with a directed pass over limits
// and corner requests. Random capture phases follow: well-formed packets with
// random headers and pixels, readbacks, stray bytes, restarts and unused
// codes. Both channels idle at random and the receiver applies one long hold.
// ----------------------------------------------------------------------------
module tb_thermal_packet_frame_assembler;

	localparam int ROW_PIXELS      = 160;
	localparam int ROW_COUNT       = 120;
	localparam int PACKET_PIXELS   = 80;
	localparam int SEGMENT_PACKETS = 60;
	localparam int FRAME_SEGMENTS  = 4;
	localparam int STORE_WORDS     = ROW_PIXELS * ROW_COUNT;
	localparam int PACKET_BYTES    = 4 + 2 * PACKET_PIXELS;
	localparam int FRAME_PACKETS   = SEGMENT_PACKETS * FRAME_SEGMENTS;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int ITEM_TARGET   = 1300;
	localparam int CALM_TAIL     = 200;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 2_500_000;
	localparam int MAX_PRINTS    = 40;

	typedef struct packed {
		logic             kind;
		tpfa_pkg::pixel_t pix;
		logic             ok;
		logic [7:0]       vcount;
		logic [9:0]       rcount;
	} frame_result_t;

	class frame_scoreboard;
		bit [15:0]     pixels [STORE_WORDS];
		bit [7:0]      byte_pos;
		bit [15:0]     hdr_word;
		bit [7:0]      hi_byte;
		bit            pkt_ok;
		int unsigned   write_base;
		int unsigned   pkts_seen;
		int unsigned   pkts_valid;
		bit            active;
		bit [9:0]      limit;
		bit [7:0]      threshold;
		frame_result_t pending [$];
		int            errors;

		function new();
			limit = tpfa_pkg::LIMIT_RESET;
			threshold = tpfa_pkg::THRESH_RESET;
		endfunction

		function void push_report();
			frame_result_t r;
			r.kind = tpfa_pkg::KIND_REPORT;
			r.pix = '0;
			r.ok = (pkts_valid >= threshold);
			r.vcount = 8'(pkts_valid);
			r.rcount = 10'(pkts_seen);
			pending.push_back(r);
		endfunction

		function void note_request(logic [1:0] req, logic [7:0] b, logic [14:0] idx);
			frame_result_t r;
			int unsigned seg, num, row_half, base, addr;
			case (req)
			tpfa_pkg::REQ_START: begin
				foreach (pixels[i]) pixels[i] = '0;
				byte_pos = 0;
				hdr_word = 0;
				hi_byte = 0;
				pkt_ok = 0;
				write_base = 0;
				pkts_seen = 0;
				pkts_valid = 0;
				active = (limit != 0);
				if (limit == 0) push_report();
			end
			tpfa_pkg::REQ_READ: begin
				r.kind = tpfa_pkg::KIND_PIXEL;
				r.pix = (idx < STORE_WORDS) ? pixels[idx] : '0;
				r.ok = 1'b0;
				r.vcount = '0;
				r.rcount = '0;
				pending.push_back(r);
			end
			tpfa_pkg::REQ_BYTE: if (active) begin
				if (byte_pos == 0) begin
					hi_byte = b;
				end else if (byte_pos == 1) begin
					hdr_word = {hi_byte, b};
					seg = hdr_word[14:12];
					num = hdr_word[11:0];
					pkt_ok = 1'b0;
					if ((hdr_word & tpfa_pkg::DISCARD_MASK) != tpfa_pkg::DISCARD_MASK
							&& seg != 0 && seg <= FRAME_SEGMENTS
							&& num < SEGMENT_PACKETS) begin
						row_half = (seg - 1) * SEGMENT_PACKETS + num;
						base = (row_half / 2) * ROW_PIXELS + (row_half % 2) * PACKET_PIXELS;
						if (base + PACKET_PIXELS <= STORE_WORDS) begin
							write_base = base;
							pkt_ok = 1'b1;
						end
					end
				end else if (byte_pos >= 4) begin
					// even offsets carry the high byte of a pixel
					if (!byte_pos[0]) begin
						hi_byte = b;
					end else if (pkt_ok) begin
						addr = write_base + (byte_pos - 4) / 2;
						if (addr < STORE_WORDS && pixels[addr] == 0)
							pixels[addr] = {hi_byte, b};
					end
				end
				if (byte_pos + 1 < PACKET_BYTES) begin
					byte_pos++;
				end else begin
					byte_pos = 0;
					pkts_seen++;
					if (pkt_ok) pkts_valid++;
					pkt_ok = 1'b0;
					if (pkts_seen >= limit || pkts_valid >= FRAME_PACKETS) begin
						active = 1'b0;
						push_report();
					end
				end
			end
			default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
		endtask

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
		endtask

		task check_result(frame_result_t got);
			frame_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result transfer with none pending, kind %0d",
					got.kind));
				return;
			end
			want = pending.pop_front();
			compare_field("result_kind", got.kind, want.kind);
			compare_field("pixel_value", got.pix, want.pix);
			compare_field("capture_ok", got.ok, want.ok);
			compare_field("accepted_count", got.vcount, want.vcount);
			compare_field("read_count", got.rcount, want.rcount);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [7:0]  rx_byte;
	logic [14:0] pixel_index;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [15:0] pixel_value;
	logic        capture_ok;
	logic [7:0]  accepted_count;
	logic [9:0]  read_count;
	logic        cfg_we;
	logic        cfg_index;
	logic [9:0]  cfg_data;

	frame_scoreboard sb;
	int items_sent = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;
	bit sender_gaps = 1'b1;
	bit hold_request = 1'b0;

	thermal_packet_frame_assembler DUT (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("thermal_packet_frame_assembler regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({result_kind, pixel_value, capture_ok, accepted_count,
				read_count});
	end

	initial begin : result_side
		int window;
		int stall;
		int hold;
		bit lazy;
		out_ready = 1'b0;
		window = 0;
		stall = 0;
		hold = 0;
		lazy = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (window == 0) begin
				window = $urandom_range(64, 512);
				lazy = ($urandom_range(0, 2) != 0);
			end
			window--;
			if (stall == 0 && lazy && !no_idle && $urandom_range(0, 9) == 0)
				stall = $urandom_range(1, 13);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [1:0] req, input logic [7:0] b, input logic [14:0] idx);
		int gap;
		gap = 0;
		if (sender_gaps && !no_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (req == tpfa_pkg::REQ_START || req == tpfa_pkg::REQ_READ
				|| (req == tpfa_pkg::REQ_BYTE && sb.active))
			items_sent++;
		if (items_sent >= ITEM_TARGET - CALM_TAIL) no_idle = 1'b1;
		in_valid <= 1'b1;
		req_type <= req;
		rx_byte <= b;
		pixel_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, b, idx);
	endtask

	task automatic send_read();
		logic [14:0] idx;
		if ($urandom_range(0, 5) == 0) idx = 15'($urandom);
		else idx = 15'(sb.write_base + $urandom_range(0, PACKET_PIXELS - 1));
		send_item(tpfa_pkg::REQ_READ, 8'($urandom), idx);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [9:0] lim, input logic [7:0] thr);
		cfg_we <= 1'b1;
		cfg_index <= tpfa_pkg::CFG_PACKET_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_index <= tpfa_pkg::CFG_SUCCESS_THRESHOLD;
		cfg_data <= {2'b00, thr};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.limit = lim;
		sb.threshold = thr;
	endtask

	function automatic logic [15:0] next_header(logic [15:0] prev);
		logic [15:0] h;
		h = 16'($urandom);
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: begin
			h[14:12] = 3'($urandom_range(1, FRAME_SEGMENTS));
			h[11:0] = 12'($urandom_range(0, SEGMENT_PACKETS - 1));
		end
		5, 6: h = prev;
		7: h[11:8] = 4'hF;
		8: begin
			h[14:12] = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(FRAME_SEGMENTS + 1, 7));
			h[11:0] = 12'($urandom_range(0, SEGMENT_PACKETS - 1));
		end
		default: begin
			h[14:12] = 3'($urandom_range(1, FRAME_SEGMENTS));
			h[11:0] = 12'($urandom_range(SEGMENT_PACKETS, 4095));
		end
		endcase
		return h;
	endfunction

	task automatic send_packet(input logic [15:0] hdr, input int nbytes);
		logic [15:0] word;
		logic [7:0] b;
		int pick;
		word = '0;
		for (int k = 0; k < nbytes; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) send_read();
			else if (pick == 3) send_item(REQ_UNUSED, 8'($urandom), 15'($urandom));
			if (k < 2) begin
				b = (k == 0) ? hdr[15:8] : hdr[7:0];
			end else if (k < 4) begin
				b = 8'($urandom);
			end else if (k % 2 == 0) begin
				word = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom);
				b = word[15:8];
			end else begin
				b = word[7:0];
			end
			send_item(tpfa_pkg::REQ_BYTE, b, 15'($urandom));
		end
	endtask

	task automatic run_capture_phase();
		logic [9:0] lim;
		logic [7:0] thr;
		logic [15:0] hdr;
		int npk;
		settle();
		case ($urandom_range(0, 5))
		0, 1: lim = 10'($urandom_range(1, 2));
		2: lim = 10'd3;
		3: lim = 10'($urandom_range(4, 1022));
		4: lim = 10'd1023;
		default: lim = 10'd0;
		endcase
		case ($urandom_range(0, 5))
		0: thr = 8'd0;
		1: thr = 8'd255;
		2: thr = 8'd240;
		3: thr = 8'($urandom_range(0, 255));
		default: thr = 8'($urandom_range(1, 3));
		endcase
		write_regs(lim, thr);
		sender_gaps = ($urandom_range(0, 2) != 0);
		send_item(tpfa_pkg::REQ_START, 8'($urandom), 15'($urandom));
		npk = (lim == 0) ? 0 : (lim <= 3) ? int'(lim) : $urandom_range(1, 2);
		hdr = next_header(16'h1000);
		// cut a packet short and restart the capture in the middle of it
		if (npk > 0 && $urandom_range(0, 4) == 0) begin
			send_packet(hdr, $urandom_range(1, PACKET_BYTES - 1));
			send_item(tpfa_pkg::REQ_START, 8'($urandom), 15'($urandom));
		end
		for (int p = 0; p < npk; p++) begin
			hdr = next_header(hdr);
			send_packet(hdr, PACKET_BYTES);
		end
		repeat (2) send_item(tpfa_pkg::REQ_BYTE, 8'($urandom), 15'($urandom));
		repeat ($urandom_range(3, 8)) send_read();
	endtask

	initial begin : stimulus
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = tpfa_pkg::REQ_START;
		rx_byte = '0;
		pixel_index = '0;
		cfg_we = 1'b0;
		cfg_index = tpfa_pkg::CFG_PACKET_LIMIT;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero limit reports straight after the clear
		write_regs(10'd0, 8'd0);
		send_item(tpfa_pkg::REQ_START, 8'hFF, 15'h7FFF);
		send_item(tpfa_pkg::REQ_BYTE, 8'hFF, 15'h7FFF);
		send_item(tpfa_pkg::REQ_BYTE, 8'h00, 15'h0000);
		send_item(REQ_UNUSED, 8'hFF, 15'h7FFF);
		send_item(tpfa_pkg::REQ_READ, 8'h00, 15'd0);
		send_item(tpfa_pkg::REQ_READ, 8'hFF, 15'(STORE_WORDS - 1));
		send_item(tpfa_pkg::REQ_READ, 8'h00, 15'(STORE_WORDS));
		send_item(tpfa_pkg::REQ_READ, 8'h00, 15'h7FFF);
		settle();
		write_regs(10'd1023, 8'd255);
		send_item(tpfa_pkg::REQ_START, 8'h00, 15'h0000);
		send_item(tpfa_pkg::REQ_READ, 8'h00, 15'd100);
		send_item(tpfa_pkg::REQ_BYTE, 8'h12, 15'h0000);
		send_item(tpfa_pkg::REQ_START, 8'h00, 15'h0000);
		// the first read goes in once the clear is over, then the receiver holds off
		send_read();
		hold_request = 1'b1;
		repeat (6) send_read();

		while (items_sent < ITEM_TARGET) run_capture_phase();

		settle();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("thermal_packet_frame_assembler regression: pass");
		else
			$display("thermal_packet_frame_assembler regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/tpfa_pkg.sv
rtl/tpfa_store.sv
rtl/thermal_packet_frame_assembler.sv
dv/tb_thermal_packet_frame_assembler.sv
